FILE: rtl/gpcc_pkg.sv
// Shared constants, types and helpers for the grid path collision checker.
// No dependencies.
package gpcc_pkg;

  localparam int MaxGridSide    = 256;
  localparam int MaxRadiusCells = 16;
  localparam int StoreAw        = 16;
  localparam int DivNw          = 33;
  localparam int DivDw          = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_RESOLUTION = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd3;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd4;
  localparam logic [2:0] REG_MAP_LOADED = 3'd5;

  localparam logic signed [7:0] OccupiedLevel = 8'sd50;

  typedef logic signed [5:0] delta_t;
  typedef logic [DivNw-1:0]  div_num_t;
  typedef logic [DivDw-1:0]  div_den_t;

  function automatic logic cell_occ(input logic [7:0] v);
    cell_occ = ($signed(v) < 0) || ($signed(v) >= OccupiedLevel);
  endfunction

endpackage

FILE: rtl/gpcc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gpcc_pkg.
module gpcc_div
  import gpcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  div_num_t num,
  input  div_den_t den,
  output logic     done,
  output div_num_t quo,
  output div_den_t rem
);

  logic [DivNw-1:0] quo_r, quo_nxt;
  logic [DivNw-1:0] rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DivNw-1:0] sh;
  logic             ge;

  assign sh = {rem_r[DivNw-2:0], quo_r[DivNw-1]};
  assign ge = sh >= {1'b0, den};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = 6'(DivNw);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (sh - {1'b0, den}) : sh;
      quo_nxt = {quo_r[DivNw-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[DivDw-1:0];

endmodule

FILE: rtl/gpcc_grid_mem.sv
// Occupancy grid store, one write and one registered read port.
// Depends on gpcc_pkg.
module gpcc_grid_mem
  import gpcc_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [StoreAw-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [StoreAw-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**StoreAw];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/grid_path_collision_check_core.sv
// Top level: sequencer around the shared divider and the grid store.
// Cell write: stored when accepted. Empty path: result set in the emit state.
// Path point: three divisions (x, y, radius), then a scan of each cell of the
// (2r+1)^2 square, 1 <= r <= 16, reading disc cells; a hit ends it early.
// Reset clears control and config registers; path state and grid stay undefined.
// Depends on gpcc_pkg, gpcc_div, gpcc_grid_mem.
module grid_path_collision_check_core
  import gpcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cell_index[15:0] cell_value[23:16] point_x[55:24] point_y[87:56]
  // vehicle_radius[118:88] path_marked_valid[119]
  input  logic [119:0] in_tdata,
  // command[1:0]
  input  logic [1:0]   in_tuser,
  // last_point
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // path_safe[0], zero fill above
  output logic [7:0]   out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIVX  = 4'd1;
  localparam logic [3:0] ST_DIVY  = 4'd2;
  localparam logic [3:0] ST_DIVR  = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_DRAIN = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;

  logic [31:0] ox_r, oy_r, res_r;
  logic [8:0]  w_r, h_r;
  logic        loaded_r;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] py_r, py_nxt;
  logic [30:0] rad_r, rad_nxt;
  logic        pmv_r, pmv_nxt, last_r, last_nxt;
  logic        clear_r, clear_nxt;
  logic        res_safe_r, res_safe_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [4:0]  rc_r, rc_nxt;
  delta_t      dx_r, dx_nxt, dy_r, dy_nxt;
  logic        pend_r, pend_nxt;
  logic        ovalid_r, ovalid_nxt, odata_r, odata_nxt;
  logic        dstart_r, dstart_nxt;
  div_num_t    dnum_r, dnum_nxt;

  logic        div_done;
  div_num_t    div_q;
  div_den_t    div_rem;

  logic        in_acc, map_valid, off_ax;
  logic [32:0] nx, ny, nyabs;
  logic [32:0] rnum;
  delta_t      rs;
  logic [4:0]  adx, ady;
  logic [9:0]  adx2, ady2;
  logic [10:0] d2;
  logic [9:0]  r2;
  logic        in_disc, offg, hit_mem;
  logic signed [9:0] gx, gy;
  logic [16:0] addr_full;
  logic        mem_we, mem_re;
  logic [7:0]  mem_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign map_valid = (res_r != '0) && (w_r != '0) && (w_r <= 9'(MaxGridSide))
                     && (h_r != '0) && (h_r <= 9'(MaxGridSide)) && loaded_r;

  assign nx    = {in_tdata[55], in_tdata[55:24]} - {ox_r[31], ox_r};
  assign ny    = {py_r[31], py_r} - {oy_r[31], oy_r};
  assign nyabs = ny[32] ? (33'd0 - ny) : ny;
  assign rnum  = {2'b00, rad_r} + {1'b0, res_r} - 33'd1;
  assign off_ax = neg_r ? ((div_q != '0) || (div_rem != '0))
                        : (state_r == ST_DIVX ? (div_q >= {24'd0, w_r})
                                              : (div_q >= {24'd0, h_r}));

  assign rs   = {1'b0, rc_r};
  assign adx  = dx_r[5] ? 5'(-dx_r) : dx_r[4:0];
  assign ady  = dy_r[5] ? 5'(-dy_r) : dy_r[4:0];
  assign adx2 = adx * adx;
  assign ady2 = ady * ady;
  assign d2   = {1'b0, adx2} + {1'b0, ady2};
  assign r2   = rc_r * rc_r;
  assign in_disc = d2 <= {1'b0, r2};
  assign gx   = $signed({2'b00, cx_r}) + $signed({{4{dx_r[5]}}, dx_r});
  assign gy   = $signed({2'b00, cy_r}) + $signed({{4{dy_r[5]}}, dy_r});
  assign offg = gx[9] || gy[9] || ($signed(gx) >= $signed({1'b0, w_r}))
                || ($signed(gy) >= $signed({1'b0, h_r}));
  assign addr_full = gy[7:0] * w_r + {9'd0, gx[7:0]};
  assign hit_mem   = pend_r && cell_occ(mem_rdata);
  assign mem_we    = in_acc && (in_tuser == CMD_WRITE);
  assign mem_re    = (state_r == ST_SCAN) && in_disc && !offg && !hit_mem;

  always_comb begin
    state_nxt    = state_r;
    py_nxt       = py_r;
    rad_nxt      = rad_r;
    pmv_nxt      = pmv_r;
    last_nxt     = last_r;
    clear_nxt    = clear_r;
    res_safe_nxt = res_safe_r;
    neg_nxt      = neg_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    rc_nxt       = rc_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    pend_nxt     = 1'b0;
    dstart_nxt   = 1'b0;
    dnum_nxt     = dnum_r;
    ovalid_nxt   = ovalid_r & ~out_tready;
    odata_nxt    = odata_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_EMPTY: begin
              clear_nxt    = 1'b1;
              res_safe_nxt = ~map_valid;
              state_nxt    = ST_EMIT;
            end
            CMD_POINT: begin
              py_nxt   = in_tdata[87:56];
              rad_nxt  = in_tdata[118:88];
              pmv_nxt  = in_tdata[119];
              last_nxt = in_tlast;
              if (map_valid && clear_r) begin
                neg_nxt    = nx[32];
                dnum_nxt   = nx[32] ? (33'd0 - nx) : nx;
                dstart_nxt = 1'b1;
                state_nxt  = ST_DIVX;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIVX, ST_DIVY: begin
        if (div_done) begin
          if (off_ax) begin
            clear_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else if (state_r == ST_DIVX) begin
            cx_nxt     = div_q[7:0];
            neg_nxt    = ny[32];
            dnum_nxt   = nyabs;
            dstart_nxt = 1'b1;
            state_nxt  = ST_DIVY;
          end else begin
            cy_nxt     = div_q[7:0];
            dnum_nxt   = rnum;
            dstart_nxt = 1'b1;
            state_nxt  = ST_DIVR;
          end
        end
      end
      ST_DIVR: begin
        if (div_done) begin
          if (div_q >= 33'(MaxRadiusCells)) begin
            rc_nxt = 5'(MaxRadiusCells);
          end else if (div_q == '0) begin
            rc_nxt = 5'd1;
          end else begin
            rc_nxt = div_q[4:0];
          end
          dx_nxt    = -delta_t'({1'b0, rc_nxt});
          dy_nxt    = -delta_t'({1'b0, rc_nxt});
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_mem || (in_disc && offg)) begin
          clear_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          pend_nxt = in_disc;
          if (dx_r == rs) begin
            dx_nxt = -rs;
            if (dy_r == rs) begin
              state_nxt = ST_DRAIN;
            end else begin
              dy_nxt = dy_r + delta_t'(1);
            end
          end else begin
            dx_nxt = dx_r + delta_t'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (hit_mem) begin
          clear_nxt = 1'b0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (last_r) begin
          res_safe_nxt = ~map_valid | (pmv_r & clear_r);
          clear_nxt    = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_safe_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      clear_r  <= 1'b1;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
      dstart_r <= 1'b0;
      ox_r     <= '0;
      oy_r     <= '0;
      res_r    <= 32'd6554;
      w_r      <= '0;
      h_r      <= '0;
      loaded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clear_r  <= clear_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
      dstart_r <= dstart_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X:   ox_r     <= cfg_data;
          REG_ORIGIN_Y:   oy_r     <= cfg_data;
          REG_RESOLUTION: res_r    <= cfg_data;
          REG_MAP_WIDTH:  w_r      <= cfg_data[8:0];
          REG_MAP_HEIGHT: h_r      <= cfg_data[8:0];
          REG_MAP_LOADED: loaded_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    py_r       <= py_nxt;
    rad_r      <= rad_nxt;
    pmv_r      <= pmv_nxt;
    last_r     <= last_nxt;
    res_safe_r <= res_safe_nxt;
    neg_r      <= neg_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    rc_r       <= rc_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dnum_r     <= dnum_nxt;
    odata_r    <= odata_nxt;
  end

  gpcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .num   (dnum_r),
    .den   (res_r),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem)
  );

  gpcc_grid_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_tdata[15:0]),
    .wdata (in_tdata[23:16]),
    .re    (mem_re),
    .raddr (addr_full[15:0]),
    .rdata (mem_rdata)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, odata_r};

endmodule

FILE: rtl/gpcc_checker.sv
// Port-level checks for the collision checker core, bound to the top level.
// Depends on gpcc_pkg and grid_path_collision_check_core.
module gpcc_checker
  import gpcc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [7:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_WRITE) && !out_tvalid |=> !out_tvalid)
    else $error("cell write produced a result");

  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_POINT) |=> !in_tready)
    else $error("point transaction did not occupy the sequencer");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind grid_path_collision_check_core gpcc_checker u_gpcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
